>>> sv/cfa_pkg.sv
// ----------------------------------------------------------------------------
// cfa_pkg: shared types and constants for the constant-folding ALU
// Command and status codes, the control record passed from front to back.
// ----------------------------------------------------------------------------
package cfa_pkg;

  localparam int unsigned VALUE_BITS_DEF  = 32;
  localparam int unsigned SYMBOL_BITS_DEF = 12;
  localparam int unsigned QUEUE_DEPTH     = 4;
  localparam int unsigned CMD_BITS        = 5;
  localparam int unsigned STATUS_BITS     = 2;

  typedef enum logic [CMD_BITS-1:0] {
    CMD_ADD   = 5'd0,
    CMD_SUB   = 5'd1,
    CMD_MUL   = 5'd2,
    CMD_DIV   = 5'd3,
    CMD_MOD   = 5'd4,
    CMD_AND   = 5'd5,
    CMD_OR    = 5'd6,
    CMD_XOR   = 5'd7,
    CMD_SHL   = 5'd8,
    CMD_SHR   = 5'd9,
    CMD_NEG   = 5'd10,
    CMD_COMPL = 5'd11,
    CMD_LNOT  = 5'd12,
    CMD_LT    = 5'd13,
    CMD_LE    = 5'd14,
    CMD_GT    = 5'd15,
    CMD_GE    = 5'd16,
    CMD_ULT   = 5'd17,
    CMD_ULE   = 5'd18,
    CMD_UGT   = 5'd19,
    CMD_UGE   = 5'd20,
    CMD_EQ    = 5'd21,
    CMD_NE    = 5'd22
  } cmd_e;

  typedef enum logic [STATUS_BITS-1:0] {
    ST_FOLDED  = 2'd0,
    ST_NOFOLD  = 2'd1,
    ST_DIVZERO = 2'd2
  } status_e;

  // Classified operation record, produced by the front end
  typedef struct packed {
    cmd_e    cmd;
    logic    named;
    logic    tfr;
    status_e status;
  } op_ctrl_t;

endpackage

>>> sv/cfa_front.sv
// ----------------------------------------------------------------------------
// cfa_front: request classifier
// Applies operand aliasing, unsigned compare remap and the symbol name rules.
// ----------------------------------------------------------------------------
module cfa_front #(
  parameter int unsigned VALUE_BITS  = cfa_pkg::VALUE_BITS_DEF,
  parameter int unsigned SYMBOL_BITS = cfa_pkg::SYMBOL_BITS_DEF
) (
  input  logic [cfa_pkg::CMD_BITS-1:0] command_i,
  input  logic [VALUE_BITS-1:0]        left_value_i,
  input  logic                         left_named_i,
  input  logic [SYMBOL_BITS-1:0]       left_symbol_i,
  input  logic                         left_unsigned_i,
  input  logic [VALUE_BITS-1:0]        right_value_i,
  input  logic                         right_named_i,
  input  logic [SYMBOL_BITS-1:0]       right_symbol_i,
  input  logic                         right_unsigned_i,
  output cfa_pkg::op_ctrl_t            ctrl_o,
  output logic [VALUE_BITS-1:0]        a_o,
  output logic [VALUE_BITS-1:0]        b_o,
  output logic [SYMBOL_BITS-1:0]       sym_o
);
  import cfa_pkg::*;

  logic                   unary;
  logic                   rn;
  logic [SYMBOL_BITS-1:0] rsym;
  logic                   ru;
  logic                   uns;
  logic                   bad_code;
  logic                   nofold;
  cmd_e                   cmd;

  always_comb begin
    unary = (command_i == CMD_NEG) || (command_i == CMD_COMPL) || (command_i == CMD_LNOT);
    b_o   = unary ? left_value_i : right_value_i;
    rn    = unary ? left_named_i : right_named_i;
    rsym  = unary ? left_symbol_i : right_symbol_i;
    ru    = unary ? left_unsigned_i : right_unsigned_i;
    uns   = left_unsigned_i || ru;
    bad_code = command_i > CMD_NE;

    // signed compares turn unsigned when either side is unsigned
    if (uns && command_i >= CMD_LT && command_i <= CMD_GE) begin
      cmd = cmd_e'(command_i + CMD_BITS'(4));
    end else begin
      cmd = cmd_e'(command_i);
    end

    nofold = (left_named_i && rn) || (rn && cmd != CMD_ADD) ||
             (left_named_i && cmd != CMD_ADD && cmd != CMD_SUB) || bad_code;

    a_o          = left_value_i;
    ctrl_o.cmd   = cmd;
    ctrl_o.named = left_named_i;
    ctrl_o.tfr   = 1'b0;
    sym_o        = left_named_i ? left_symbol_i : '0;

    if (nofold) begin
      ctrl_o.status = ST_NOFOLD;
    end else if ((cmd == CMD_DIV || cmd == CMD_MOD) && b_o == '0) begin
      ctrl_o.status = ST_DIVZERO;
    end else begin
      ctrl_o.status = ST_FOLDED;
    end

    // an add with an unnamed left takes the right side's name and type
    if (!nofold && cmd == CMD_ADD && !left_named_i) begin
      ctrl_o.named = rn;
      ctrl_o.tfr   = 1'b1;
      sym_o        = rn ? rsym : '0;
    end
  end

endmodule

>>> sv/cfa_queue.sv
// ----------------------------------------------------------------------------
// cfa_queue: short FIFO between classifier and execution pipeline
// Holds classified operations so that each side can stall on its own.
// ----------------------------------------------------------------------------
module cfa_queue #(
  parameter int unsigned VALUE_BITS  = cfa_pkg::VALUE_BITS_DEF,
  parameter int unsigned SYMBOL_BITS = cfa_pkg::SYMBOL_BITS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   push_i,
  output logic                   full_o,
  input  cfa_pkg::op_ctrl_t      ctrl_i,
  input  logic [VALUE_BITS-1:0]  a_i,
  input  logic [VALUE_BITS-1:0]  b_i,
  input  logic [SYMBOL_BITS-1:0] sym_i,
  input  logic                   pop_i,
  output logic                   empty_o,
  output cfa_pkg::op_ctrl_t      ctrl_o,
  output logic [VALUE_BITS-1:0]  a_o,
  output logic [VALUE_BITS-1:0]  b_o,
  output logic [SYMBOL_BITS-1:0] sym_o
);
  import cfa_pkg::*;

  localparam int unsigned PW = $clog2(QUEUE_DEPTH);
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

  op_ctrl_t               ctrl_q [QUEUE_DEPTH];
  logic [VALUE_BITS-1:0]  a_q    [QUEUE_DEPTH];
  logic [VALUE_BITS-1:0]  b_q    [QUEUE_DEPTH];
  logic [SYMBOL_BITS-1:0] sym_q  [QUEUE_DEPTH];
  logic [PW-1:0]          wr_q, wr_d, rd_q, rd_d;
  logic [CW-1:0]          cnt_q, cnt_d;
  logic                   do_push, do_pop;

  assign full_o  = cnt_q == CW'(QUEUE_DEPTH);
  assign empty_o = cnt_q == '0;
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign ctrl_o  = ctrl_q[rd_q];
  assign a_o     = a_q[rd_q];
  assign b_o     = b_q[rd_q];
  assign sym_o   = sym_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_q + PW'(1);
    end
    if (do_pop) begin
      rd_d = (rd_q == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_q + PW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      ctrl_q[wr_q] <= ctrl_i;
      a_q[wr_q]    <= a_i;
      b_q[wr_q]    <= b_i;
      sym_q[wr_q]  <= sym_i;
    end
  end

endmodule

>>> sv/cfa_back.sv
// ----------------------------------------------------------------------------
// cfa_back: execution pipeline
// Issue stage for the non-divide ops and operand prep, one restoring divider
// stage per quotient bit, then sign fix into the output register.
// ----------------------------------------------------------------------------
module cfa_back #(
  parameter int unsigned VALUE_BITS  = cfa_pkg::VALUE_BITS_DEF,
  parameter int unsigned SYMBOL_BITS = cfa_pkg::SYMBOL_BITS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   empty_i,
  output logic                   pop_o,
  input  cfa_pkg::op_ctrl_t      ctrl_i,
  input  logic [VALUE_BITS-1:0]  a_i,
  input  logic [VALUE_BITS-1:0]  b_i,
  input  logic [SYMBOL_BITS-1:0] sym_i,
  output logic                   valid_o,
  input  logic                   ready_i,
  output logic [VALUE_BITS-1:0]  value_o,
  output logic                   named_o,
  output logic [SYMBOL_BITS-1:0] sym_o,
  output logic                   tfr_o,
  output cfa_pkg::status_e       status_o
);
  import cfa_pkg::*;

  localparam int unsigned VB  = VALUE_BITS;
  localparam int unsigned SHW = $clog2(VB);

  logic                   vld_q  [VB+1];
  op_ctrl_t               ctrl_q [VB+1];
  logic [VB-1:0]          val_q  [VB+1];
  logic [SYMBOL_BITS-1:0] sym_q  [VB+1];
  logic [VB-1:0]          r_q    [VB+1];
  logic [VB-1:0]          qa_q   [VB+1];
  logic [VB-1:0]          d_q    [VB+1];
  logic                   na_q   [VB+1];
  logic                   nb_q   [VB+1];
  logic [VB-1:0]          r_d    [VB+1];
  logic [VB-1:0]          qa_d   [VB+1];

  logic          adv;
  logic [VB-1:0] res0;
  logic          na, nb, big;
  logic [VB:0]   rs;
  logic          ge;
  logic [VB-1:0] fix;
  logic          out_vld_q;

  assign adv     = !out_vld_q || ready_i;
  assign pop_o   = adv && !empty_i;
  assign valid_o = out_vld_q;
  assign na      = a_i[VB-1];
  assign nb      = b_i[VB-1];
  assign big     = b_i >= VB'(VB);

  // non-divide operations, computed combinationally from the queue head
  always_comb begin
    res0 = a_i;
    if (ctrl_i.status == ST_FOLDED) begin
      case (ctrl_i.cmd)
        CMD_ADD:   res0 = a_i + b_i;
        CMD_SUB:   res0 = a_i - b_i;
        CMD_MUL:   res0 = a_i * b_i;
        CMD_AND:   res0 = a_i & b_i;
        CMD_OR:    res0 = a_i | b_i;
        CMD_XOR:   res0 = a_i ^ b_i;
        CMD_SHL:   res0 = big ? '0 : a_i << b_i[SHW-1:0];
        CMD_SHR:   res0 = big ? {VB{na}} : VB'($signed(a_i) >>> b_i[SHW-1:0]);
        CMD_NEG:   res0 = '0 - a_i;
        CMD_COMPL: res0 = ~a_i;
        CMD_LNOT:  res0 = VB'(a_i == '0);
        CMD_LT:    res0 = VB'($signed(a_i) < $signed(b_i));
        CMD_LE:    res0 = VB'($signed(a_i) <= $signed(b_i));
        CMD_GT:    res0 = VB'($signed(a_i) > $signed(b_i));
        CMD_GE:    res0 = VB'($signed(a_i) >= $signed(b_i));
        CMD_ULT:   res0 = VB'(a_i < b_i);
        CMD_ULE:   res0 = VB'(a_i <= b_i);
        CMD_UGT:   res0 = VB'(a_i > b_i);
        CMD_UGE:   res0 = VB'(a_i >= b_i);
        CMD_EQ:    res0 = VB'(a_i == b_i);
        CMD_NE:    res0 = VB'(a_i != b_i);
        default:   res0 = a_i;
      endcase
    end
  end

  // one restoring division step per stage
  always_comb begin
    r_d[0]  = '0;
    qa_d[0] = '0;
    for (int k = 1; k <= VB; k++) begin
      rs      = {r_q[k-1], qa_q[k-1][VB-1]};
      ge      = rs >= {1'b0, d_q[k-1]};
      r_d[k]  = ge ? VB'(rs - {1'b0, d_q[k-1]}) : rs[VB-1:0];
      qa_d[k] = {qa_q[k-1][VB-2:0], ge};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k <= VB; k++) begin
        vld_q[k] <= 1'b0;
      end
      out_vld_q <= 1'b0;
    end else if (adv) begin
      vld_q[0] <= !empty_i;
      for (int k = 1; k <= VB; k++) begin
        vld_q[k] <= vld_q[k-1];
      end
      out_vld_q <= vld_q[VB];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      ctrl_q[0] <= ctrl_i;
      val_q[0]  <= res0;
      sym_q[0]  <= sym_i;
      r_q[0]    <= '0;
      qa_q[0]   <= na ? '0 - a_i : a_i;
      d_q[0]    <= nb ? '0 - b_i : b_i;
      na_q[0]   <= na;
      nb_q[0]   <= nb;
      for (int k = 1; k <= VB; k++) begin
        ctrl_q[k] <= ctrl_q[k-1];
        val_q[k]  <= val_q[k-1];
        sym_q[k]  <= sym_q[k-1];
        r_q[k]    <= r_d[k];
        qa_q[k]   <= qa_d[k];
        d_q[k]    <= d_q[k-1];
        na_q[k]   <= na_q[k-1];
        nb_q[k]   <= nb_q[k-1];
      end
      value_o  <= fix;
      named_o  <= ctrl_q[VB].named;
      sym_o    <= sym_q[VB];
      tfr_o    <= ctrl_q[VB].tfr;
      status_o <= ctrl_q[VB].status;
    end
  end

  // restore quotient and remainder signs
  always_comb begin
    fix = val_q[VB];
    if (ctrl_q[VB].status == ST_FOLDED && ctrl_q[VB].cmd == CMD_DIV) begin
      fix = (na_q[VB] ^ nb_q[VB]) ? '0 - qa_q[VB] : qa_q[VB];
    end else if (ctrl_q[VB].status == ST_FOLDED && ctrl_q[VB].cmd == CMD_MOD) begin
      fix = na_q[VB] ? '0 - r_q[VB] : r_q[VB];
    end
  end

endmodule

>>> sv/constant_fold_alu.sv
// ----------------------------------------------------------------------------
// constant_fold_alu: constant-folding ALU
// Folds one operator over two constants with symbol name rules and status.
// ----------------------------------------------------------------------------
// Channel   Dir  Fields (low bit first)
// s_axis    in   command, left_value, left_named, left_symbol, left_unsigned,
//                right_value, right_named, right_symbol, right_unsigned
// m_axis    out  result_value, result_named, result_symbol, type_from_right,
//                status
//
// One transaction per cycle sustained while m_axis_tready_i is high; each
// result passes the queue, the issue stage, one divider stage per quotient
// bit and the output register, in that order.
// Reset clears the queue pointers and count and the pipeline valid bits only.
// An output stall freezes the pipeline; the queue (4 entries) keeps
// accepting until full, so s_axis_tready drops only on a full queue.
// ----------------------------------------------------------------------------
module constant_fold_alu #(
  parameter int unsigned VALUE_BITS  = cfa_pkg::VALUE_BITS_DEF,
  parameter int unsigned SYMBOL_BITS = cfa_pkg::SYMBOL_BITS_DEF,
  parameter int unsigned IN_W  = cfa_pkg::CMD_BITS + 2 * (VALUE_BITS + SYMBOL_BITS + 2),
  parameter int unsigned OUT_W = VALUE_BITS + SYMBOL_BITS + 2 + cfa_pkg::STATUS_BITS
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  // command, left_value, left_named, left_symbol, left_unsigned,
  // right_value, right_named, right_symbol, right_unsigned
  input  logic [((IN_W + 7) / 8) * 8-1:0]  s_axis_tdata_i,
  output logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i,
  // result_value, result_named, result_symbol, type_from_right, status
  output logic [((OUT_W + 7) / 8) * 8-1:0] m_axis_tdata_o
);
  import cfa_pkg::*;

  localparam int unsigned VB      = VALUE_BITS;
  localparam int unsigned SB      = SYMBOL_BITS;
  localparam int unsigned O_LV    = CMD_BITS;
  localparam int unsigned O_LN    = O_LV + VB;
  localparam int unsigned O_LS    = O_LN + 1;
  localparam int unsigned O_LU    = O_LS + SB;
  localparam int unsigned O_RV    = O_LU + 1;
  localparam int unsigned O_RN    = O_RV + VB;
  localparam int unsigned O_RS    = O_RN + 1;
  localparam int unsigned O_RU    = O_RS + SB;
  localparam int unsigned OUT_PAD = ((OUT_W + 7) / 8) * 8;

  op_ctrl_t      f_ctrl, q_ctrl;
  logic [VB-1:0] f_a, f_b, q_a, q_b;
  logic [SB-1:0] f_sym, q_sym;
  logic          q_full, q_empty, q_pop;
  logic [VB-1:0] res_value;
  logic          res_named, res_tfr;
  logic [SB-1:0] res_sym;
  status_e       res_status;

  // classify the incoming transaction combinationally
  cfa_front #(.VALUE_BITS(VB), .SYMBOL_BITS(SB)) u_front (
    .command_i       (s_axis_tdata_i[CMD_BITS-1:0]),
    .left_value_i    (s_axis_tdata_i[O_LV +: VB]),
    .left_named_i    (s_axis_tdata_i[O_LN]),
    .left_symbol_i   (s_axis_tdata_i[O_LS +: SB]),
    .left_unsigned_i (s_axis_tdata_i[O_LU]),
    .right_value_i   (s_axis_tdata_i[O_RV +: VB]),
    .right_named_i   (s_axis_tdata_i[O_RN]),
    .right_symbol_i  (s_axis_tdata_i[O_RS +: SB]),
    .right_unsigned_i(s_axis_tdata_i[O_RU]),
    .ctrl_o          (f_ctrl),
    .a_o             (f_a),
    .b_o             (f_b),
    .sym_o           (f_sym)
  );

  assign s_axis_tready_o = !q_full;

  // decouple classifier from execution
  cfa_queue #(.VALUE_BITS(VB), .SYMBOL_BITS(SB)) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (s_axis_tvalid_i),
    .full_o (q_full),
    .ctrl_i (f_ctrl),
    .a_i    (f_a),
    .b_i    (f_b),
    .sym_i  (f_sym),
    .pop_i  (q_pop),
    .empty_o(q_empty),
    .ctrl_o (q_ctrl),
    .a_o    (q_a),
    .b_o    (q_b),
    .sym_o  (q_sym)
  );

  // execute; the output register sits at the end of this pipeline
  cfa_back #(.VALUE_BITS(VB), .SYMBOL_BITS(SB)) u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .empty_i (q_empty),
    .pop_o   (q_pop),
    .ctrl_i  (q_ctrl),
    .a_i     (q_a),
    .b_i     (q_b),
    .sym_i   (q_sym),
    .valid_o (m_axis_tvalid_o),
    .ready_i (m_axis_tready_i),
    .value_o (res_value),
    .named_o (res_named),
    .sym_o   (res_sym),
    .tfr_o   (res_tfr),
    .status_o(res_status)
  );

  // pack result fields, low bit first, zero fill to whole bytes
  assign m_axis_tdata_o = OUT_PAD'({res_status, res_tfr, res_sym, res_named, res_value});

endmodule
